// ----- rtl/wrrp_pkg.sv -----
// Shared types and constants of the weighted round-robin pause arbiter.
// Holds the opcode, item and result types used by the core and the top level.
// No dependencies.
package wrrp_pkg;

    localparam int MAX_QUEUES = 8;
    localparam logic [7:0] WEIGHT_RESET = 8'd1;
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_PAUSE    = 2'd1,
        OP_RESUME   = 2'd2
    } opcode_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [2:0]  queue_id;
        logic [7:0]  ready_mask;
    } item_t;

    typedef struct packed {
        logic        grant_valid;
        logic [2:0]  grant_queue;
        logic        any_pullable;
    } result_t;

endpackage

// ----- rtl/wrrp_core.sv -----
// Scheduling core: credit buckets, pause counters and the grant decision for one word.
// State advances on each step; the decision is combinational from the current state.
// Depends on wrrp_pkg.
module wrrp_core #(
    parameter int NUM_QUEUES = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  wrrp_pkg::item_t              item,
    input  logic [NUM_QUEUES-1:0][7:0]   weight,
    output wrrp_pkg::result_t            result
);
    import wrrp_pkg::*;

    logic [NUM_QUEUES-1:0][7:0] bucket_reg, bucket_next;
    logic [NUM_QUEUES-1:0][7:0] pause_reg, pause_next;

    logic       hit_found, fw_found, best_found;
    logic [2:0] hit_q, fw_q, best_q;

    always_comb begin
        result      = '0;
        bucket_next = bucket_reg;
        pause_next  = pause_reg;
        hit_found   = 1'b0;
        fw_found    = 1'b0;
        best_found  = 1'b0;
        hit_q       = '0;
        fw_q        = '0;
        best_q      = '0;

        for (int q = 0; q < NUM_QUEUES; q++) begin
            if (item.ready_mask[q] && pause_reg[q] == 8'd0) begin
                result.any_pullable = 1'b1;
            end
            if (item.ready_mask[q]) begin
                if (bucket_reg[q] != 8'd0) begin
                    if (!hit_found) begin
                        hit_found = 1'b1;
                        hit_q     = 3'(q);
                    end
                end else if (weight[q] != 8'd0) begin
                    if (!fw_found) begin
                        fw_found = 1'b1;
                        fw_q     = 3'(q);
                    end
                end else if (!best_found) begin
                    best_found = 1'b1;
                    best_q     = 3'(q);
                end
            end
        end

        case (item.opcode)
            OP_SCHEDULE: begin
                if (hit_found) begin
                    result.grant_valid = 1'b1;
                    result.grant_queue = hit_q;
                    for (int q = 0; q < NUM_QUEUES; q++) begin
                        if (hit_q == 3'(q)) begin
                            bucket_next[q] = bucket_reg[q] - 8'd1;
                        end
                    end
                end else if (fw_found) begin
                    result.grant_valid = 1'b1;
                    result.grant_queue = fw_q;
                    for (int q = 0; q < NUM_QUEUES; q++) begin
                        bucket_next[q] = weight[q] - ((fw_q == 3'(q)) ? 8'd1 : 8'd0);
                    end
                end else if (best_found) begin
                    result.grant_valid = 1'b1;
                    result.grant_queue = best_q;
                end
            end
            OP_PAUSE: begin
                for (int q = 0; q < NUM_QUEUES; q++) begin
                    if (item.queue_id == 3'(q) && pause_reg[q] != COUNT_MAX) begin
                        pause_next[q] = pause_reg[q] + 8'd1;
                    end
                end
            end
            OP_RESUME: begin
                for (int q = 0; q < NUM_QUEUES; q++) begin
                    if (item.queue_id == 3'(q) && pause_reg[q] != 8'd0) begin
                        pause_next[q] = pause_reg[q] - 8'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                bucket_reg[q] <= WEIGHT_RESET;
                pause_reg[q]  <= 8'd0;
            end
        end else if (step) begin
            bucket_reg <= bucket_next;
            pause_reg  <= pause_next;
        end
    end

`ifndef SYNTH
    a_grant_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        result.grant_valid |-> item.ready_mask[result.grant_queue])
        else $error("grant to a queue that is not ready");

    a_grant_sched_only: assert property (@(posedge aclk) disable iff (!aresetn)
        item.opcode != OP_SCHEDULE |-> !result.grant_valid)
        else $error("grant on a pause or resume word");

    a_no_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !result.grant_valid |-> result.grant_queue == 3'd0)
        else $error("queue index without grant");

    a_pause_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && item.opcode == OP_SCHEDULE) |=> $stable(pause_reg))
        else $error("pause counts changed by a schedule word");
`endif

endmodule

// ----- rtl/weighted_round_robin_pause_arbiter_top.sv -----
// Weighted round-robin output-port scheduler with per-queue pause counters, top level.
// Holds the stream handshake, input and result registers and the weight registers.
// Depends on wrrp_pkg and wrrp_core.
//
// The rate is one word per cycle unless m_tready stalls it, set by the combinational
// eight-way priority scan and bucket update in wrrp_core. Schedule words (tuser 0)
// return a grant when the ready mask is nonzero; pause (1) and resume (2) words adjust
// the named queue's pause count. Weights must be written through the cfg port while
// idle (the block does not enforce this) and take effect at the next bucket reload.
module weighted_round_robin_pause_arbiter_top #(
    parameter int NUM_QUEUES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // queue_id[2:0], ready_mask[10:3], zero fill
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // grant_queue[2:0], any_pullable[3], zero fill
    output logic        m_tuser    // grant_valid
);
    import wrrp_pkg::*;

    logic                       in_valid_reg;
    item_t                      in_item_reg;
    logic                       out_valid_reg;
    result_t                    out_res_reg;
    logic [NUM_QUEUES-1:0][7:0] weight_reg;
    result_t                    core_res;
    logic                       out_free;
    logic                       step;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.opcode     <= opcode_t'(s_tuser);
            in_item_reg.queue_id   <= s_tdata[2:0];
            in_item_reg.ready_mask <= s_tdata[10:3];
        end
        if (step) begin
            out_res_reg <= core_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                weight_reg[q] <= WEIGHT_RESET;
            end
        end else if (cfg_we) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                if (cfg_index == 3'(q)) begin
                    weight_reg[q] <= cfg_wdata;
                end
            end
        end
    end

    wrrp_core #(
        .NUM_QUEUES(NUM_QUEUES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .weight  (weight_reg),
        .result  (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.grant_valid;
    assign m_tdata  = {4'b0000, out_res_reg.any_pullable, out_res_reg.grant_queue};

endmodule
